// ===== hdl/hrsp_pkg.sv =====
`default_nettype none

package hrsp_pkg;

  // Field and register widths
  localparam int DATA_W           = 8;
  localparam int CFG_W            = 64;
  localparam int CFG_IDX_W        = 3;
  localparam int LEN_W            = 6;
  localparam int POS_W            = 6;
  localparam int MCOUNT_W         = 3;
  localparam int CHARS_PER_WORD   = 8;
  localparam int ENDPOINT_MAX_DEF = 32;
  localparam int ENDPOINT_CAP     = 32;
  localparam int QUEUE_DEPTH      = 2;

  // Characters the parser looks for
  localparam logic [DATA_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [DATA_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [DATA_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [DATA_W-1:0] CHAR_COLON = 8'h3A;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EP_0_7   = 3'd0,
    REG_EP_8_15  = 3'd1,
    REG_EP_16_23 = 3'd2,
    REG_EP_24_31 = 3'd3,
    REG_EP_LEN   = 3'd4
  } reg_index_t;

  typedef enum logic [3:0] {
    CLS_LETTER = 4'd0,
    CLS_DIGIT  = 4'd1,
    CLS_CR     = 4'd2,
    CLS_LF     = 4'd3,
    CLS_BLANK  = 4'd4,
    CLS_SLASH  = 4'd5,
    CLS_DOT    = 4'd6,
    CLS_COLON  = 4'd7,
    CLS_OTHER  = 4'd8
  } byte_class_t;

  typedef enum logic [3:0] {
    EV_IGNORED      = 4'd0,
    EV_METHOD_BYTE  = 4'd1,
    EV_METHOD_END   = 4'd2,
    EV_PATH_BYTE    = 4'd3,
    EV_PATH_END     = 4'd4,
    EV_VERSION_BYTE = 4'd5,
    EV_LINE_END     = 4'd6,
    EV_KEY          = 4'd7,
    EV_VALUE        = 4'd8,
    EV_HEADER_END   = 4'd9,
    EV_HEADERS_DONE = 4'd10,
    EV_BODY         = 4'd11,
    EV_MALFORMED    = 4'd12
  } event_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_METHOD  = 3'd1,
    PH_PATH    = 3'd2,
    PH_VERSION = 3'd3,
    PH_HEADER  = 3'd4,
    PH_BODY    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    PART_KEY   = 2'd0,
    PART_SKIP  = 2'd1,
    PART_VALUE = 2'd2
  } part_t;

  typedef enum logic [1:0] {
    METHOD_NONE    = 2'd0,
    METHOD_GET     = 2'd1,
    METHOD_POST    = 2'd2,
    METHOD_UNKNOWN = 2'd3
  } method_t;

  // One classified byte as it travels from the front to the back
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              end_of_request;
    byte_class_t       byte_class;
  } entry_t;

  function automatic byte_class_t classify(input logic [DATA_W-1:0] b);
    byte_class_t c;
    c = CLS_OTHER;
    if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) c = CLS_LETTER;
    else if (b >= 8'h30 && b <= 8'h39) c = CLS_DIGIT;
    else if (b == CHAR_CR) c = CLS_CR;
    else if (b == CHAR_LF) c = CLS_LF;
    else if (b == CHAR_SPACE || b == CHAR_TAB) c = CLS_BLANK;
    else if (b == CHAR_SLASH) c = CLS_SLASH;
    else if (b == CHAR_DOT) c = CLS_DOT;
    else if (b == CHAR_COLON) c = CLS_COLON;
    return c;
  endfunction

  // Letters of "GET", by position
  function automatic logic [DATA_W-1:0] get_char(input logic [MCOUNT_W-1:0] i);
    logic [DATA_W-1:0] c;
    unique case (i)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h45;
      3'd2:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Letters of "POST", by position
  function automatic logic [DATA_W-1:0] post_char(input logic [MCOUNT_W-1:0] i);
    logic [DATA_W-1:0] c;
    unique case (i)
      3'd0:    c = 8'h50;
      3'd1:    c = 8'h4F;
      3'd2:    c = 8'h53;
      3'd3:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/hrsp_in_if.sv =====
`default_nettype none

interface hrsp_in_if;
  import hrsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              end_of_request;

  modport source (output valid, output data_byte, output end_of_request, input ready);
  modport sink (input valid, input data_byte, input end_of_request, output ready);
endinterface

`default_nettype wire

// ===== hdl/hrsp_out_if.sv =====
`default_nettype none

interface hrsp_out_if;
  import hrsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [3:0]        event_res;
  logic [DATA_W-1:0] echo_byte;
  logic [3:0]        byte_class;
  logic [1:0]        method_code;
  logic              path_matches;

  modport source (
    output valid, output event_res, output echo_byte, output byte_class,
    output method_code, output path_matches, input ready
  );
  modport sink (
    input valid, input event_res, input echo_byte, input byte_class,
    input method_code, input path_matches, output ready
  );
endinterface

`default_nettype wire

// ===== hdl/hrsp_front.sv =====
`default_nettype none

module hrsp_front (
  input  wire logic            clk,
  input  wire logic            rst,
  hrsp_in_if.sink              req,
  output hrsp_pkg::entry_t     push_entry,
  output logic                 push_valid,
  input  wire logic            push_ready
);
  import hrsp_pkg::*;

  logic   stage_valid;
  entry_t stage;

  // The stage frees up whenever the queue takes its beat
  assign req.ready = !stage_valid || push_ready;

  // Classify the incoming byte and hold it for the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage.data_byte      <= req.data_byte;
      stage.end_of_request <= req.end_of_request;
      stage.byte_class     <= classify(req.data_byte);
    end
  end

  assign push_valid = stage_valid;
  assign push_entry = stage;

endmodule

`default_nettype wire

// ===== hdl/hrsp_queue.sv =====
`default_nettype none

module hrsp_queue (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire hrsp_pkg::entry_t                   push_entry,
  input  wire logic                               push_valid,
  output logic                                    push_ready,
  output hrsp_pkg::entry_t                        pop_entry,
  output logic                                    pop_valid,
  input  wire logic                               pop_ready,
  output logic [$clog2(hrsp_pkg::QUEUE_DEPTH+1)-1:0] level
);
  import hrsp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];
  assign level      = count;

  // Pointers wrap at the depth; the count tracks occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hrsp_back.sv =====
`default_nettype none

module hrsp_back #(
  parameter int ENDPOINT_MAX = hrsp_pkg::ENDPOINT_MAX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [hrsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hrsp_pkg::CFG_W-1:0]        cfg_data,
  input  wire hrsp_pkg::entry_t                  pop_entry,
  input  wire logic                              pop_valid,
  output logic                                   pop_ready,
  hrsp_out_if.source                             res
);
  import hrsp_pkg::*;

  localparam int EP_CHARS = (ENDPOINT_MAX < ENDPOINT_CAP) ? ENDPOINT_MAX : ENDPOINT_CAP;
  localparam int IDX_W    = $clog2(EP_CHARS);

  // Endpoint configuration
  logic [DATA_W-1:0] ep_char [EP_CHARS];
  logic [LEN_W-1:0]  ep_length;
  logic [LEN_W-1:0]  eff_len;

  // Parser state
  phase_t              phase, phase_next;
  logic                cr_pending, cr_pending_next;
  logic                line_empty, line_empty_next;
  part_t               header_part, header_part_next;
  logic [MCOUNT_W-1:0] method_count, method_count_next;
  logic                could_get, could_get_next;
  logic                could_post, could_post_next;
  method_t             decided_method, decided_method_next;
  logic [POS_W-1:0]    path_position, path_position_next;
  logic                path_equal, path_equal_next;
  logic                path_result, path_result_next;

  // Output register
  logic              out_valid;
  event_t            out_event;
  logic [DATA_W-1:0] out_byte;
  byte_class_t       out_class;
  method_t           out_method;
  logic              out_match;

  byte_class_t       cls;
  logic [DATA_W-1:0] b;
  logic              had_cr;
  logic              is_letter;
  logic              get_ok;
  logic              post_ok;
  logic              pos_hit;
  event_t            ev;
  logic              pop;

  assign cls       = pop_entry.byte_class;
  assign b         = pop_entry.data_byte;
  assign had_cr    = cr_pending;
  assign is_letter = (cls == CLS_LETTER);
  assign pop_ready = !out_valid || res.ready;
  assign pop       = pop_valid && pop_ready;

  // Endpoint registers, one byte lane per character
  for (genvar j = 0; j < EP_CHARS; j++) begin : g_ep
    always_ff @(posedge clk) begin
      if (rst) begin
        ep_char[j] <= (j == 0) ? CHAR_SLASH : '0;
      end else if (cfg_we && cfg_index == CFG_IDX_W'(j / CHARS_PER_WORD)) begin
        ep_char[j] <= cfg_data[(j % CHARS_PER_WORD) * DATA_W +: DATA_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ep_length <= LEN_W'(1);
    end else if (cfg_we && cfg_index == REG_EP_LEN) begin
      ep_length <= cfg_data[LEN_W-1:0];
    end
  end

  assign eff_len = (ep_length > LEN_W'(EP_CHARS)) ? LEN_W'(EP_CHARS) : ep_length;

  // Method and path comparisons for the current byte
  assign get_ok  = (method_count < 3'd3) && (get_char(method_count) == b);
  assign post_ok = (method_count < 3'd4) && (post_char(method_count) == b);
  assign pos_hit = (path_position < eff_len) && (ep_char[path_position[IDX_W-1:0]] == b);

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_METHOD: begin
        if (cls == CLS_BLANK) phase_next = PH_PATH;
      end
      PH_PATH: begin
        if (cls == CLS_BLANK) phase_next = PH_VERSION;
      end
      PH_VERSION: begin
        if (cls == CLS_LF && had_cr) phase_next = PH_HEADER;
      end
      PH_HEADER: begin
        if (cls == CLS_LF && had_cr && line_empty) phase_next = PH_BODY;
      end
      PH_BODY: begin
        phase_next = PH_BODY;
      end
      default: begin
        phase_next = is_letter ? PH_METHOD : PH_IDLE;
      end
    endcase
  end

  // Event and the rest of the parser state
  always_comb begin
    cr_pending_next     = (cls == CLS_CR);
    line_empty_next     = line_empty;
    header_part_next    = header_part;
    method_count_next   = method_count;
    could_get_next      = could_get;
    could_post_next     = could_post;
    decided_method_next = decided_method;
    path_position_next  = path_position;
    path_equal_next     = path_equal;
    path_result_next    = path_result;
    ev                  = EV_IGNORED;
    unique case (phase)
      PH_METHOD: begin
        if (is_letter) begin
          if (!get_ok) could_get_next = 1'b0;
          if (!post_ok) could_post_next = 1'b0;
          if (method_count != '1) method_count_next = method_count + 1'b1;
          ev = EV_METHOD_BYTE;
        end else if (cls == CLS_BLANK) begin
          if (could_get && method_count == 3'd3) decided_method_next = METHOD_GET;
          else if (could_post && method_count == 3'd4) decided_method_next = METHOD_POST;
          else decided_method_next = METHOD_UNKNOWN;
          ev = EV_METHOD_END;
        end
      end
      PH_PATH: begin
        if (is_letter || cls == CLS_SLASH) begin
          if (!pos_hit) path_equal_next = 1'b0;
          if (path_position != '1) path_position_next = path_position + 1'b1;
          ev = EV_PATH_BYTE;
        end else if (cls == CLS_BLANK) begin
          path_result_next = path_equal && (path_position == eff_len);
          ev = EV_PATH_END;
        end
      end
      PH_VERSION: begin
        if (is_letter || cls == CLS_DIGIT || cls == CLS_SLASH || cls == CLS_DOT) begin
          ev = EV_VERSION_BYTE;
        end else if (cls == CLS_LF && had_cr) begin
          line_empty_next  = 1'b1;
          header_part_next = PART_KEY;
          ev = EV_LINE_END;
        end
      end
      PH_HEADER: begin
        if (cls == CLS_LF) begin
          if (had_cr) begin
            if (line_empty) ev = EV_HEADERS_DONE;
            else if (header_part == PART_KEY) ev = EV_MALFORMED;
            else ev = EV_HEADER_END;
            line_empty_next  = 1'b1;
            header_part_next = PART_KEY;
          end
        end else if (cls != CLS_CR) begin
          line_empty_next = 1'b0;
          unique case (header_part)
            PART_KEY: begin
              if (cls == CLS_COLON) header_part_next = PART_SKIP;
              else ev = EV_KEY;
            end
            PART_SKIP: begin
              header_part_next = PART_VALUE;
            end
            default: begin
              ev = EV_VALUE;
            end
          endcase
        end
      end
      PH_BODY: begin
        if (is_letter) ev = EV_BODY;
      end
      default: begin
        if (is_letter) begin
          if (!get_ok) could_get_next = 1'b0;
          if (!post_ok) could_post_next = 1'b0;
          if (method_count != '1) method_count_next = method_count + 1'b1;
          ev = EV_METHOD_BYTE;
        end
      end
    endcase
  end

  // State update; the last byte of a request returns the parser to idle
  always_ff @(posedge clk) begin
    if (rst || (pop && pop_entry.end_of_request)) begin
      phase          <= PH_IDLE;
      cr_pending     <= 1'b0;
      line_empty     <= 1'b1;
      header_part    <= PART_KEY;
      method_count   <= '0;
      could_get      <= 1'b1;
      could_post     <= 1'b1;
      decided_method <= METHOD_NONE;
      path_position  <= '0;
      path_equal     <= 1'b1;
      path_result    <= 1'b0;
    end else if (pop) begin
      phase          <= phase_next;
      cr_pending     <= cr_pending_next;
      line_empty     <= line_empty_next;
      header_part    <= header_part_next;
      method_count   <= method_count_next;
      could_get      <= could_get_next;
      could_post     <= could_post_next;
      decided_method <= decided_method_next;
      path_position  <= path_position_next;
      path_equal     <= path_equal_next;
      path_result    <= path_result_next;
    end
  end

  // Result register toward the sink
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_event  <= ev;
      out_byte   <= b;
      out_class  <= cls;
      out_method <= decided_method_next;
      out_match  <= path_result_next;
    end
  end

  assign res.valid        = out_valid;
  assign res.event_res    = out_event;
  assign res.echo_byte    = out_byte;
  assign res.byte_class   = out_class;
  assign res.method_code  = out_method;
  assign res.path_matches = out_match;

endmodule

`default_nettype wire

// ===== hdl/http_request_stream_parser.sv =====
`default_nettype none

// Channel  Dir  Beat carries
// req      in   data_byte, end_of_request
// res      out  event_res, echo_byte, byte_class, method_code, path_matches
// cfg_*    in   endpoint words 0..3, endpoint length (write only)
//
// One byte per cycle sustained while res is ready; each byte passes from req to res
// through the classify register, the two-entry queue and the result register.
// The parser state machine in the back end settles one byte per cycle while res is ready.
// Reset is synchronous and restores the endpoint to "/" with length 1.
// A stalled res fills the queue first; req drops ready only once the queue
// and the classify register are both full.

module http_request_stream_parser #(
  parameter int ENDPOINT_MAX = hrsp_pkg::ENDPOINT_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [hrsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hrsp_pkg::CFG_W-1:0]     cfg_data,
  hrsp_in_if.sink                             req,
  hrsp_out_if.source                          res
);
  import hrsp_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           push_entry;
  logic             push_valid;
  logic             push_ready;
  entry_t           pop_entry;
  logic             pop_valid;
  logic             pop_ready;
  logic [CNT_W-1:0] level;

  // Front end: accept and classify
  hrsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // Decoupling queue
  hrsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_entry  (pop_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .level      (level)
  );

  // Back end: parser state machine and result register
  hrsp_back #(
    .ENDPOINT_MAX (ENDPOINT_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop_entry (pop_entry),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .res       (res)
  );

  // Queue never overfills
  assert property (@(posedge clk) disable iff (rst) level <= CNT_W'(QUEUE_DEPTH))
    else $error("queue level above depth");

  // Occupancy moves by at most one beat per cycle
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (level == $past(level) || level == $past(level) + 1'b1 ||
                     level + 1'b1 == $past(level)))
    else $error("queue level jumped");

  // Method and path ends are reported only on a blank
  assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.event_res == EV_METHOD_END || res.event_res == EV_PATH_END)
      |-> res.byte_class == CLS_BLANK)
    else $error("part end without blank");

  // Line-end events are reported only on a line feed
  assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.event_res == EV_LINE_END || res.event_res == EV_HEADER_END ||
                  res.event_res == EV_HEADERS_DONE || res.event_res == EV_MALFORMED)
      |-> res.byte_class == CLS_LF)
    else $error("line end without line feed");

endmodule

`default_nettype wire
